// ===== rtl/core/qvr_pkg.sv =====
`timescale 1ns / 1ps

package qvr_pkg;

	localparam int DATA_WIDTH = 16;

	// normalized magnitude width and the shift that brings the largest one under it
	localparam int AM_W    = 16;
	localparam int MAG_LIM = 65535;
	localparam int SH_MAX  = (DATA_WIDTH > AM_W + 1) ? DATA_WIDTH - AM_W - 1 : 0;
	localparam int SH_W    = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

	// square root of the sum of squares scaled by 2^28
	localparam int S_W  = 2 * AM_W + 2;
	localparam int SQ_W = S_W + 30;
	localparam int NSQ  = SQ_W / 2;
	localparam int M_W  = S_W / 2 + 15;

	// unit quaternion division
	localparam int DV_W = AM_W + 32;
	localparam int Q_W  = 17;
	localparam int QN_W = Q_W + 1;

	// hamilton products
	localparam int P1_W = DATA_WIDTH + QN_W;
	localparam int TS_W = P1_W + 2;
	localparam int T_W  = TS_W - 7;
	localparam int P2_W = QN_W + T_W;
	localparam int RS_W = P2_W + 2;
	localparam int R_W  = RS_W - 23;

	localparam int IN_BITS  = 7 * DATA_WIDTH;
	localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 3 * DATA_WIDTH;
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

	localparam int LAT = 3 + NSQ + Q_W + 6;

	typedef struct packed {
		logic [2:0][DATA_WIDTH-1:0] v;
		logic [3:0]                 neg;
		logic [3:0][AM_W-1:0]       am;
		logic                       deg;
	} carry_t;

endpackage

// ===== rtl/core/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps

// Rotates a 3-vector by a quaternion as q * (v,0) * conj(q). The quaternion is normalized
// inside (Q2.16), the vector is rotated at its own integer scale, results are rounded to
// nearest and saturated to the signed range. An all-zero vector or quaternion gives a zero
// result with tuser (degenerate) set. One transaction is accepted every cycle while the output
// is not stalled. The pipeline holds the 32-stage bit-per-stage square root and the 17-stage
// quotient pipeline for the unit quaternion. Back-pressure on the output stalls the whole
// pipeline in step, so s_tready follows m_tready while a result waits.
module quaternion_vector_rotate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
	input  logic [qvr_pkg::IN_TW-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_x, out_y, out_z
	output logic [qvr_pkg::OUT_TW-1:0]  m_tdata,
	// degenerate
	output logic [0:0]                  m_tuser
);

	localparam int DW   = qvr_pkg::DATA_WIDTH;
	localparam int LAT  = qvr_pkg::LAT;
	localparam int NSQ  = qvr_pkg::NSQ;
	localparam int Q_W  = qvr_pkg::Q_W;
	localparam int SQ_W = qvr_pkg::SQ_W;
	localparam int DV_W = qvr_pkg::DV_W;
	localparam int AM_W = qvr_pkg::AM_W;
	localparam int QN_W = qvr_pkg::QN_W;
	localparam int M_W  = qvr_pkg::M_W;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: magnitudes, signs, degenerate flag
	logic [3:0][DW-1:0]     qin;
	logic [3:0][DW-1:0]     am_full;
	logic [DW-1:0]          mx;
	logic [qvr_pkg::SH_W-1:0] sh;
	qvr_pkg::carry_t        c_in;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qin[i]     = s_tdata[(3 + i) * DW +: DW];
			am_full[i] = qin[i][DW-1] ? DW'(-qin[i]) : qin[i];
		end
		mx = am_full[0];
		for (int i = 1; i < 4; i++) begin
			if (am_full[i] > mx) mx = am_full[i];
		end
		sh = '0;
		for (int s = qvr_pkg::SH_MAX; s >= 0; s--) begin
			if ((mx >> s) <= DW'(qvr_pkg::MAG_LIM)) sh = qvr_pkg::SH_W'(s);
		end
		for (int i = 0; i < 3; i++) c_in.v[i] = s_tdata[i * DW +: DW];
		for (int i = 0; i < 4; i++) begin
			c_in.neg[i] = qin[i][DW-1];
			c_in.am[i]  = AM_W'(am_full[i] >> sh);
		end
		c_in.deg = (c_in.v == '0) || (mx == '0);
	end

	qvr_pkg::carry_t c_s1, c_s2, c_s3;
	logic [3:0][2*AM_W-1:0]       sq_s2;
	logic [qvr_pkg::S_W-1:0]      ssum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c_in;
			c_s2 <= c_s1;
			for (int i = 0; i < 4; i++) sq_s2[i] <= c_s1.am[i] * c_s1.am[i];
			c_s3 <= c_s2;
			ssum_s3 <= qvr_pkg::S_W'(sq_s2[0]) + qvr_pkg::S_W'(sq_s2[1])
				+ qvr_pkg::S_W'(sq_s2[2]) + qvr_pkg::S_W'(sq_s2[3]);
		end
	end

	// square root, one result bit per stage
	logic [SQ_W-1:0]  sqrt_n_s [1:NSQ];
	logic [SQ_W-1:0]  sqrt_r_s [1:NSQ];
	qvr_pkg::carry_t  sqrt_c_s [1:NSQ];

	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int K = NSQ - 1 - j;
		logic [SQ_W-1:0] n_cur, r_cur, bitv, trial, n_nx, r_nx;
		qvr_pkg::carry_t c_cur;
		if (j == 0) begin : g_first
			assign n_cur = SQ_W'(ssum_s3) << 28;
			assign r_cur = '0;
			assign c_cur = c_s3;
		end else begin : g_next
			assign n_cur = sqrt_n_s[j];
			assign r_cur = sqrt_r_s[j];
			assign c_cur = sqrt_c_s[j];
		end
		always_comb begin
			bitv  = SQ_W'(1) << (2 * K);
			trial = r_cur + bitv;
			if (n_cur >= trial) begin
				n_nx = n_cur - trial;
				r_nx = (r_cur >> 1) + bitv;
			end else begin
				n_nx = n_cur;
				r_nx = r_cur >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_n_s[j+1] <= n_nx;
				sqrt_r_s[j+1] <= r_nx;
				sqrt_c_s[j+1] <= c_cur;
			end
		end
	end

	// unit components: round((am << 30) / m), one quotient bit per stage on four lanes
	logic [M_W-1:0]             m_root;
	logic [3:0][DV_W-1:0]       div_r0;
	logic [3:0][DV_W-1:0]       div_r_s [1:Q_W];
	logic [3:0][Q_W-1:0]        div_q_s [1:Q_W];
	logic [M_W-1:0]             div_m_s [1:Q_W];
	qvr_pkg::carry_t            div_c_s [1:Q_W];

	assign m_root = M_W'(sqrt_r_s[NSQ]);
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			div_r0[i] = (DV_W'(sqrt_c_s[NSQ].am[i]) << 30) + DV_W'(m_root >> 1);
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int K = Q_W - 1 - j;
		logic [DV_W-1:0]      dsh;
		logic [3:0][DV_W-1:0] r_cur, r_nx;
		logic [3:0][Q_W-1:0]  q_cur, q_nx;
		logic [M_W-1:0]       m_cur;
		qvr_pkg::carry_t      c_cur;
		if (j == 0) begin : g_first
			assign r_cur = div_r0;
			assign q_cur = '0;
			assign m_cur = m_root;
			assign c_cur = sqrt_c_s[NSQ];
		end else begin : g_next
			assign r_cur = div_r_s[j];
			assign q_cur = div_q_s[j];
			assign m_cur = div_m_s[j];
			assign c_cur = div_c_s[j];
		end
		always_comb begin
			dsh = DV_W'(m_cur) << K;
			for (int i = 0; i < 4; i++) begin
				q_nx[i] = q_cur[i];
				if (r_cur[i] >= dsh) begin
					r_nx[i]    = r_cur[i] - dsh;
					q_nx[i][K] = 1'b1;
				end else begin
					r_nx[i] = r_cur[i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_r_s[j+1] <= r_nx;
				div_q_s[j+1] <= q_nx;
				div_m_s[j+1] <= m_cur;
				div_c_s[j+1] <= c_cur;
			end
		end
	end

	// first product t = (v,0) * conj(qn)
	qvr_pkg::carry_t                        cd;
	logic signed [3:0][QN_W-1:0]            qn;
	logic signed [QN_W-1:0]                 qc0, qc1, qc2, qc3;
	logic signed [DW-1:0]                   v0, v1, v2;

	always_comb begin
		cd = div_c_s[Q_W];
		for (int i = 0; i < 4; i++) begin
			qn[i] = cd.neg[i] ? -$signed({1'b0, div_q_s[Q_W][i]})
				: $signed({1'b0, div_q_s[Q_W][i]});
		end
		qc0 = -qn[0];
		qc1 = -qn[1];
		qc2 = -qn[2];
		qc3 = qn[3];
		v0  = $signed(cd.v[0]);
		v1  = $signed(cd.v[1]);
		v2  = $signed(cd.v[2]);
	end

	logic signed [qvr_pkg::P1_W-1:0] p1_s53 [12];
	logic signed [3:0][QN_W-1:0]     qn_s53, qn_s54, qn_s55;
	logic                            deg_s53, deg_s54, deg_s55, deg_s56, deg_s57;
	logic signed [qvr_pkg::TS_W-1:0] ts_s54 [4];
	logic signed [qvr_pkg::T_W-1:0]  t_s55 [4];
	logic signed [qvr_pkg::P2_W-1:0] p2_s56 [12];
	logic signed [qvr_pkg::RS_W-1:0] rs_s57 [3];
	logic [2:0][DW-1:0]              out_s58;
	logic                            deg_s58;

	// rounding of t by 8 bits, ties away from zero
	logic [qvr_pkg::TS_W-1:0] tmag [4];
	logic [qvr_pkg::TS_W-1:0] trnd [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tmag[i] = ts_s54[i][qvr_pkg::TS_W-1] ? qvr_pkg::TS_W'(-ts_s54[i])
				: qvr_pkg::TS_W'(ts_s54[i]);
			trnd[i] = (tmag[i] + qvr_pkg::TS_W'(128)) >> 8;
		end
	end

	// rounding of r by 24 bits and saturation
	localparam logic signed [qvr_pkg::R_W-1:0] HI = qvr_pkg::R_W'((64'sd1 <<< (DW - 1)) - 1);
	localparam logic signed [qvr_pkg::R_W-1:0] LO = -HI - qvr_pkg::R_W'(1);
	logic [qvr_pkg::RS_W-1:0]       rmag [3];
	logic [qvr_pkg::RS_W-1:0]       rrnd [3];
	logic signed [qvr_pkg::R_W-1:0] rval [3];
	logic [2:0][DW-1:0]             osat;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rmag[i] = rs_s57[i][qvr_pkg::RS_W-1] ? qvr_pkg::RS_W'(-rs_s57[i])
				: qvr_pkg::RS_W'(rs_s57[i]);
			rrnd[i] = (rmag[i] + (qvr_pkg::RS_W'(1) << 23)) >> 24;
			rval[i] = rs_s57[i][qvr_pkg::RS_W-1] ? -$signed(qvr_pkg::R_W'(rrnd[i]))
				: $signed(qvr_pkg::R_W'(rrnd[i]));
			priority if (rval[i] > HI) osat[i] = DW'(HI);
			else if (rval[i] < LO)     osat[i] = DW'(LO);
			else                       osat[i] = DW'(rval[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s53[0]  <= v0 * qc3;
			p1_s53[1]  <= v1 * qc2;
			p1_s53[2]  <= v2 * qc1;
			p1_s53[3]  <= v1 * qc3;
			p1_s53[4]  <= v2 * qc0;
			p1_s53[5]  <= v0 * qc2;
			p1_s53[6]  <= v2 * qc3;
			p1_s53[7]  <= v0 * qc1;
			p1_s53[8]  <= v1 * qc0;
			p1_s53[9]  <= v0 * qc0;
			p1_s53[10] <= v1 * qc1;
			p1_s53[11] <= v2 * qc2;
			qn_s53  <= qn;
			deg_s53 <= cd.deg;

			ts_s54[0] <= qvr_pkg::TS_W'(p1_s53[0]) + qvr_pkg::TS_W'(p1_s53[1])
				- qvr_pkg::TS_W'(p1_s53[2]);
			ts_s54[1] <= qvr_pkg::TS_W'(p1_s53[3]) + qvr_pkg::TS_W'(p1_s53[4])
				- qvr_pkg::TS_W'(p1_s53[5]);
			ts_s54[2] <= qvr_pkg::TS_W'(p1_s53[6]) + qvr_pkg::TS_W'(p1_s53[7])
				- qvr_pkg::TS_W'(p1_s53[8]);
			ts_s54[3] <= -qvr_pkg::TS_W'(p1_s53[9]) - qvr_pkg::TS_W'(p1_s53[10])
				- qvr_pkg::TS_W'(p1_s53[11]);
			qn_s54  <= qn_s53;
			deg_s54 <= deg_s53;

			for (int i = 0; i < 4; i++) begin
				t_s55[i] <= ts_s54[i][qvr_pkg::TS_W-1] ? -$signed(qvr_pkg::T_W'(trnd[i]))
					: $signed(qvr_pkg::T_W'(trnd[i]));
			end
			qn_s55  <= qn_s54;
			deg_s55 <= deg_s54;

			// second product r = qn * t, vector part only
			p2_s56[0]  <= $signed(qn_s55[3]) * t_s55[0];
			p2_s56[1]  <= $signed(qn_s55[0]) * t_s55[3];
			p2_s56[2]  <= $signed(qn_s55[1]) * t_s55[2];
			p2_s56[3]  <= $signed(qn_s55[2]) * t_s55[1];
			p2_s56[4]  <= $signed(qn_s55[3]) * t_s55[1];
			p2_s56[5]  <= $signed(qn_s55[1]) * t_s55[3];
			p2_s56[6]  <= $signed(qn_s55[2]) * t_s55[0];
			p2_s56[7]  <= $signed(qn_s55[0]) * t_s55[2];
			p2_s56[8]  <= $signed(qn_s55[3]) * t_s55[2];
			p2_s56[9]  <= $signed(qn_s55[2]) * t_s55[3];
			p2_s56[10] <= $signed(qn_s55[0]) * t_s55[1];
			p2_s56[11] <= $signed(qn_s55[1]) * t_s55[0];
			deg_s56 <= deg_s55;

			for (int i = 0; i < 3; i++) begin
				rs_s57[i] <= qvr_pkg::RS_W'(p2_s56[4*i]) + qvr_pkg::RS_W'(p2_s56[4*i+1])
					+ qvr_pkg::RS_W'(p2_s56[4*i+2]) - qvr_pkg::RS_W'(p2_s56[4*i+3]);
			end
			deg_s57 <= deg_s56;

			out_s58 <= deg_s57 ? '0 : osat;
			deg_s58 <= deg_s57;
		end
	end

	assign m_tdata = qvr_pkg::OUT_TW'(out_s58);
	assign m_tuser = deg_s58;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("degenerate result with non-zero vector");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted transaction not in first stage");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

endmodule

// ===== dv/quaternion_vector_rotate_test.sv =====
`timescale 1ns / 1ps

module quaternion_vector_rotate_test;

	localparam int DW = qvr_pkg::DATA_WIDTH;

	typedef struct {
		logic [DW-1:0] ox, oy, oz;
		logic          degen;
	} rotation_t;

	class rotation_scoreboard;
		rotation_t pending[$];
		int        errors = 0;

		static function longint round_shift(longint x, int k);
			longint m;
			m = (x < 0) ? -x : x;
			m = (m + (longint'(1) << (k - 1))) >>> k;
			return (x < 0) ? -m : m;
		endfunction

		static function longint clamp(longint x);
			longint hi, lo;
			hi = (longint'(1) << (DW - 1)) - 1;
			lo = -hi - 1;
			if (x > hi) x = hi;
			if (x < lo) x = lo;
			return x;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function void hprod(longint a[4], longint b[4], output longint r[4]);
			r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
			r[1] = a[3]*b[1] + a[1]*b[3] + a[2]*b[0] - a[0]*b[2];
			r[2] = a[3]*b[2] + a[2]*b[3] + a[0]*b[1] - a[1]*b[0];
			r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
		endfunction

		function void note_input(logic signed [DW-1:0] f[7]);
			longint v[4], q[4], qn[4], qc[4], t[4], r[4];
			longint unsigned am[4], mx, s, m, u;
			int sh;
			rotation_t e;
			mx = 0;
			s = 0;
			sh = 0;
			for (int i = 0; i < 3; i++) v[i] = f[i];
			v[3] = 0;
			for (int i = 0; i < 4; i++) begin
				q[i] = f[3+i];
				am[i] = (q[i] < 0) ? -q[i] : q[i];
				if (am[i] > mx) mx = am[i];
			end
			if ((v[0] == 0 && v[1] == 0 && v[2] == 0) || mx == 0) begin
				e = '{ox: '0, oy: '0, oz: '0, degen: 1'b1};
				pending.push_back(e);
				return;
			end
			while ((mx >> sh) > 65535) sh++;
			for (int i = 0; i < 4; i++) begin
				am[i] >>= sh;
				s += am[i] * am[i];
			end
			m = int_sqrt(s << 28);
			for (int i = 0; i < 4; i++) begin
				u = ((am[i] << 30) + m / 2) / m;
				qn[i] = (q[i] < 0) ? -longint'(u) : longint'(u);
			end
			qc[0] = -qn[0]; qc[1] = -qn[1]; qc[2] = -qn[2]; qc[3] = qn[3];
			hprod(v, qc, t);
			for (int i = 0; i < 4; i++) t[i] = round_shift(t[i], 8);
			hprod(qn, t, r);
			e.ox = DW'(clamp(round_shift(r[0], 24)));
			e.oy = DW'(clamp(round_shift(r[1], 24)));
			e.oz = DW'(clamp(round_shift(r[2], 24)));
			e.degen = 1'b0;
			pending.push_back(e);
		endfunction

		function void check_result(logic [DW-1:0] ax, ay, az, logic ad);
			rotation_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ax !== e.ox) begin
				$error("out_x expected %0d actual %0d", $signed(e.ox), $signed(ax)); errors++;
			end
			if (ay !== e.oy) begin
				$error("out_y expected %0d actual %0d", $signed(e.oy), $signed(ay)); errors++;
			end
			if (az !== e.oz) begin
				$error("out_z expected %0d actual %0d", $signed(e.oz), $signed(az)); errors++;
			end
			if (ad !== e.degen) begin
				$error("degenerate expected %0d actual %0d", e.degen, ad); errors++;
			end
		endfunction
	endclass

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       s_tvalid = 0;
	logic                       s_tready;
	logic [qvr_pkg::IN_TW-1:0]  s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 0;
	logic [qvr_pkg::OUT_TW-1:0] m_tdata;
	logic [0:0]                 m_tuser;

	rotation_scoreboard sb = new();
	longint cycles = 0;
	int     stall_mode = 0;

	always #6 clk = ~clk;

	quaternion_vector_rotate u_dut (.*);

	// receiver: stall pattern changes between phases
	always @(posedge clk) begin
		cycles <= cycles + 1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (cycles[3:0] < 11);
		endcase
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[0 +: DW], m_tdata[DW +: DW], m_tdata[2*DW +: DW],
				m_tuser[0]);
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("quaternion_vector_rotate_test failed");
			$finish;
		end
	end

	// present one rotation and hold it until the transaction completes
	task automatic send_rotation(logic signed [DW-1:0] f[7]);
		logic [qvr_pkg::IN_TW-1:0] d;
		d = '0;
		for (int i = 0; i < 7; i++) d[i*DW +: DW] = f[i];
		s_tdata  <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(f);
	endtask

	task automatic idle_cycles(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] rand_field(int kind);
		case (kind)
			0: return DW'($urandom);
			1: return DW'($urandom_range(0, 31) - 16);
			2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			default: return DW'($urandom_range(0, 32767) - 16384);
		endcase
	endfunction

	initial begin
		logic signed [DW-1:0] f[7];
		int burst;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axes, extremes, zero vector, zero quaternion, saturation
		f = '{100, 0, 0, 0, 0, 0, 16384}; send_rotation(f);
		f = '{100, -200, 300, 0, 0, 11585, 11585}; send_rotation(f);
		f = '{1000, 2000, 3000, 16384, 0, 0, 0}; send_rotation(f);
		f = '{0, 0, 0, 100, 200, 300, 400}; send_rotation(f);
		f = '{5, 6, 7, 0, 0, 0, 0}; send_rotation(f);
		f = '{0, 0, 0, 0, 0, 0, 0}; send_rotation(f);
		f = '{32767, 32767, 32767, 0, 0, 11585, 11585}; send_rotation(f);
		f = '{-32768, -32768, -32768, 0, 11585, 0, 11585}; send_rotation(f);
		f = '{32767, -32768, 1, -32768, -32768, -32768, -32768}; send_rotation(f);
		f = '{-1, 1, -1, 32767, 32767, 32767, 32767}; send_rotation(f);
		f = '{32767, 0, 0, 1, 0, 0, 0}; send_rotation(f);
		f = '{0, 0, -32768, 0, -1, 0, 0}; send_rotation(f);
		f = '{1, 1, 1, 1, 1, 1, 1}; send_rotation(f);
		f = '{-32768, 32767, -32768, 0, 0, 0, -32768}; send_rotation(f);
		f = '{12345, -23456, 7, 9, -8, 7, -6}; send_rotation(f);
		idle_cycles(1);
		// hold off until the pipeline has drained
		while (sb.pending.size() != 0) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			stall_mode = ph;
			for (int n = 0; n < 360; ) begin
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst; b++, n++) begin
					for (int i = 0; i < 7; i++) f[i] = rand_field($urandom_range(0, 5));
					if ($urandom_range(0, 40) == 0) f[0:2] = '{0, 0, 0};
					if ($urandom_range(0, 40) == 0) f[3:6] = '{0, 0, 0, 0};
					send_rotation(f);
				end
				if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
			end
			idle_cycles(1);
			if (ph == 1)
				while (sb.pending.size() != 0) @(posedge clk);
		end
		s_tvalid <= 1'b0;
		stall_mode = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (qvr_pkg::LAT + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("quaternion_vector_rotate_test passed");
		else
			$display("quaternion_vector_rotate_test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/qvr_pkg.sv
rtl/core/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_test.sv
